// File: hw/rtl/sfr_pkg.sv
// Package: shared types and constants for the serial frame receiver.
package sfr_pkg;

    localparam int SLOTS     = 8;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    localparam logic [7:0] HDR_A     = 8'hAA;
    localparam logic [7:0] HDR_B     = 8'hBB;
    localparam logic [7:0] HDR_2     = 8'h83;
    localparam logic [7:0] MIN_LEN   = 8'd2;
    localparam logic [7:0] LEN_LIM_RST  = 8'd32;
    localparam logic [7:0] IDLE_LIM_RST = 8'd20;

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT   = 1'b1;

    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_SUM  = 3'd4
    } phase_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } in_req_t;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic [2:0] slot_index;
        logic       frame_done;
        logic       frame_good;
        logic       idle_reset;
    } out_res_t;

    typedef struct packed {
        logic [7:0] length_limit;
        logic [7:0] idle_limit;
    } cfg_t;

endpackage

// File: hw/rtl/serial_frame_receiver.sv
// Top level: request register, frame parser, result register, config registers.
//
//  port group   dir  handshake            payload
//  in_*         in   in_valid / in_ready  in_req  (req_type, rx_byte)
//  out_*        out  out_valid / out_ready out_res (data/frame/idle flags)
//  cfg_*        in   cfg_we               cfg_addr, cfg_wdata
//
// One request per cycle while out_ready is high; out_valid follows the result register.
// The request register feeds the parser, whose result is loaded into the result register.
// A stalled result holds the pipe; the request register still fills behind it.
// Reset returns the parser to header search and restores the limit registers.
module serial_frame_receiver
    import sfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_req_t              in_req,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_res_t             out_res,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic     req_valid_reg;
    in_req_t  req_reg;
    logic     res_valid_reg;
    out_res_t res_reg;
    out_res_t res_next;
    cfg_t     cfg_reg;
    logic     advance;

    assign advance   = req_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready  = !req_valid_reg || advance;
    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;

    sfr_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .req   (req_reg),
        .cfg   (cfg_reg),
        .res   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            cfg_reg.length_limit <= LEN_LIM_RST;
            cfg_reg.idle_limit   <= IDLE_LIM_RST;
        end
        else
        begin
            if (in_ready)
                req_valid_reg <= in_valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (out_ready)
                res_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_LENGTH_LIMIT: cfg_reg.length_limit <= cfg_wdata;
                    REG_IDLE_LIMIT:   cfg_reg.idle_limit   <= cfg_wdata;
                    default:          cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            req_reg <= in_req;
        if (advance)
            res_reg <= res_next;
    end

`ifndef NO_ASSERTIONS
    a_good_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_res.frame_good || out_res.frame_done))
        else $error("frame_good without frame_done");

    a_data_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_res.data_valid && out_res.frame_done))
        else $error("payload byte and check byte in one result");

    a_timeout_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_res.idle_reset |-> !out_res.data_valid && !out_res.frame_done)
        else $error("timeout result carries frame content");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !req_valid_reg |-> in_ready)
        else $error("empty request register not ready");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("result register not loaded after advance");
`endif

endmodule

// File: hw/rtl/sfr_parser.sv
// Frame parser: parse state registers and the per-request next-state logic.
module sfr_parser
    import sfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  in_req_t  req,
    input  cfg_t     cfg,
    output out_res_t res
);

    phase_t            phase_reg, phase_next;
    logic [7:0]        idle_reg, idle_next;
    logic [7:0]        len_reg, len_next;
    logic [7:0]        cnt_reg, cnt_next;
    logic [7:0]        chk_reg, chk_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W+2:0] slot_ext;
    logic [8:0]        cnt_inc;
    logic              timeout;
    phase_t            phase_cur;

    assign timeout  = (idle_reg > cfg.idle_limit);
    assign cnt_inc  = {1'b0, cnt_reg} + 9'd1;
    assign slot_ext = {3'b000, slot_reg};

    always_comb
    begin
        phase_cur  = timeout ? PH_HDR1 : phase_reg;
        phase_next = phase_cur;
        idle_next  = timeout ? 8'd0 : idle_reg + 8'd1;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        chk_next   = chk_reg;
        slot_next  = slot_reg;

        res            = '0;
        res.slot_index = slot_ext[2:0];
        res.idle_reset = timeout;

        if (req.req_type)
        begin
            idle_next = 8'd0;
            case (phase_cur)
                PH_HDR1:
                begin
                    if (req.rx_byte == HDR_A || req.rx_byte == HDR_B)
                        phase_next = PH_HDR2;
                end
                PH_HDR2:
                begin
                    phase_next = (req.rx_byte == HDR_2) ? PH_LEN : PH_HDR1;
                end
                PH_LEN:
                begin
                    len_next = req.rx_byte;
                    if (req.rx_byte >= cfg.length_limit || req.rx_byte < MIN_LEN)
                    begin
                        phase_next = PH_HDR1;
                    end
                    else
                    begin
                        chk_next   = req.rx_byte;
                        cnt_next   = 8'd0;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    res.data_valid = 1'b1;
                    res.data_byte  = req.rx_byte;
                    res.data_index = cnt_reg;
                    chk_next       = chk_reg ^ req.rx_byte;
                    cnt_next       = cnt_inc[7:0];
                    // length counts the check byte, so the payload ends one early
                    if ((cnt_inc + 9'd1) >= {1'b0, len_reg})
                        phase_next = PH_SUM;
                end
                PH_SUM:
                begin
                    res.frame_done = 1'b1;
                    if (chk_reg == req.rx_byte)
                    begin
                        res.frame_good = 1'b1;
                        slot_next = (slot_reg == SLOT_W'(SLOTS - 1)) ? '0
                                                                      : slot_reg + 1'b1;
                    end
                    phase_next = PH_HDR1;
                end
                default:
                begin
                    phase_next = PH_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR1;
            idle_reg  <= '0;
            len_reg   <= '0;
            cnt_reg   <= '0;
            chk_reg   <= '0;
            slot_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            idle_reg  <= idle_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            chk_reg   <= chk_next;
            slot_reg  <= slot_next;
        end
    end

endmodule
